[rtl/core/ddo_pkg.sv]
// Package for the differential-drive odometry block.
// Holds widths, register indexes, CORDIC constants and the arctangent table.
// No dependencies.
`timescale 1ns / 1ps
package ddo_pkg;

    localparam int CordicStepsDefault = 16;
    localparam int CordicStepsMax     = 32;

    localparam logic [1:0] REG_UM_PER_PULSE = 2'd0;
    localparam logic [1:0] REG_TRACK_WIDTH  = 2'd1;
    localparam logic [1:0] REG_STEP_PERIOD  = 2'd2;

    localparam int CfgAddrW = 2;
    localparam int CfgDataW = 24;

    // CORDIC datapath width: wheel difference needs 42 bits, the track 37,
    // growth through the vectoring pass adds a couple more.
    localparam int CW = 48;

    localparam logic signed [CW-1:0] GAIN_Q30 = 48'sd652032874;
    localparam logic [47:0] TURN_TWO32 = 48'd154618822656000; // 36000 * 2^32

    // ceil(2^53 / 1125): heading * HEAD_RECIP >> 26 is exactly
    // floor(heading * 2^32 / 36000) for every heading below 36000.
    localparam logic [42:0] HEAD_RECIP = 43'd8006399337548;

    function automatic logic [31:0] atan_lookup(input logic [4:0] i);
        logic [31:0] t;
        case (i)
            5'd0:  t = 32'h20000000;
            5'd1:  t = 32'h12E4051E;
            5'd2:  t = 32'h09FB385B;
            5'd3:  t = 32'h051111D4;
            5'd4:  t = 32'h028B0D43;
            5'd5:  t = 32'h0145D7E1;
            5'd6:  t = 32'h00A2F61E;
            5'd7:  t = 32'h00517C55;
            5'd8:  t = 32'h0028BE53;
            5'd9:  t = 32'h00145F2F;
            5'd10: t = 32'h000A2F98;
            5'd11: t = 32'h000517CC;
            5'd12: t = 32'h00028BE6;
            5'd13: t = 32'h000145F3;
            5'd14: t = 32'h0000A2F9;
            5'd15: t = 32'h0000517D;
            5'd16: t = 32'h000028BE;
            5'd17: t = 32'h0000145F;
            5'd18: t = 32'h00000A30;
            5'd19: t = 32'h00000518;
            5'd20: t = 32'h0000028C;
            5'd21: t = 32'h00000146;
            5'd22: t = 32'h000000A3;
            5'd23: t = 32'h00000051;
            5'd24: t = 32'h00000029;
            5'd25: t = 32'h00000014;
            5'd26: t = 32'h0000000A;
            5'd27: t = 32'h00000005;
            5'd28: t = 32'h00000003;
            5'd29: t = 32'h00000001;
            5'd30: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

    typedef struct packed {
        logic       kind;
        logic [15:0] pulses_right;
        logic [15:0] pulses_left;
        logic       reverse_right;
        logic       reverse_left;
        logic signed [15:0] set_x_mm;
        logic signed [15:0] set_y_mm;
        logic [8:0] set_heading_deg;
    } odo_in_t;

    typedef struct packed {
        logic signed [31:0] x_um;
        logic signed [31:0] y_um;
        logic [15:0]        heading_centideg;
        logic signed [15:0] speed_mm_s;
    } odo_out_t;

    // Command to the CORDIC unit.
    typedef struct packed {
        logic                 start;
        logic                 vectoring;
        logic signed [CW-1:0] x0;
        logic signed [CW-1:0] y0;
        logic signed [32:0]   z0;
    } cordic_cmd_t;

    typedef struct packed {
        logic                 done;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [32:0]   z;
    } cordic_rsp_t;

endpackage

[rtl/core/ddo_stream_if.sv]
// Valid/ready channel carrying one odometry word.
// Depends on nothing; the payload type is a parameter.
`timescale 1ns / 1ps
interface ddo_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/ddo_cordic.sv]
// Iterative CORDIC: one micro-rotation per cycle, rotation or vectoring mode.
// Depends on ddo_pkg.
`timescale 1ns / 1ps
module ddo_cordic
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = CordicStepsDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cordic_cmd_t cmd,
    output cordic_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 vec_reg, vec_next;
    logic [5:0]           step_reg, step_next;
    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [32:0]   z_reg, z_next;
    logic                 done_reg, done_next;

    logic signed [CW-1:0] dx, dy;
    logic signed [32:0]   at;
    logic                 go_pos;

    always_comb
    begin
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        at = {1'b0, atan_lookup(step_reg[4:0])};
        go_pos = vec_reg ? (y_reg > 0) : (z_reg >= 0);

        busy_next = busy_reg;
        vec_next  = vec_reg;
        step_next = step_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        done_next = 1'b0;

        if (cmd.start)
        begin
            busy_next = 1'b1;
            vec_next  = cmd.vectoring;
            step_next = '0;
            x_next    = cmd.x0;
            y_next    = cmd.y0;
            z_next    = cmd.z0;
        end
        else if (busy_reg)
        begin
            // In vectoring mode a zero residual leaves x, y and z untouched.
            if (!(vec_reg && y_reg == 0))
            begin
                if (go_pos == vec_reg)
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                end
                else
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                end
                if (go_pos)
                    z_next = vec_reg ? z_reg + at : z_reg - at;
                else
                    z_next = vec_reg ? z_reg - at : z_reg + at;
            end
            step_next = step_reg + 6'd1;
            if (step_reg == 6'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            vec_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            vec_reg  <= vec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign rsp.done = done_reg;
    assign rsp.x    = x_reg;
    assign rsp.y    = y_reg;
    assign rsp.z    = z_reg;

endmodule

[rtl/core/ddo_divider.sv]
// Restoring divider for magnitudes: one quotient bit per cycle.
// Depends on ddo_pkg for nothing but house style; widths are parameters.
`timescale 1ns / 1ps
module ddo_divider
    import ddo_pkg::*;
#(
    parameter int NW = 48,
    parameter int DW = 48
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot,
    output logic [DW-1:0] rem
);

    localparam int CntW = $clog2(NW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CntW-1:0] cnt_reg;
    logic [NW-1:0]   q_reg;
    logic [DW-1:0]   r_reg;
    logic [DW-1:0]   d_reg;
    logic [DW:0]     trial;

    assign trial = {r_reg, q_reg[NW-1]} - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CntW'(1);
                if (cnt_reg == CntW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!trial[DW])
            begin
                r_reg <= trial[DW-1:0];
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= {r_reg[DW-2:0], q_reg[NW-1]};
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

[rtl/core/differential_drive_odometry.sv]
// Differential-drive odometry, top level with sequencer and pose registers.
// Depends on ddo_pkg, ddo_stream_if, ddo_cordic and ddo_divider.
// A tick word runs the two CORDIC passes and the speed divide before its result
// appears; a pose word loads position and heading directly. One word is in flight
// at a time; the next is taken in the cycle after the result leaves. Reset clears
// pose and speed and loads the configuration registers with their defaults.
`timescale 1ns / 1ps
module differential_drive_odometry
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = CordicStepsDefault
)
(
    input  logic                clk,
    input  logic                rst_n,
    ddo_stream_if.sink          in_ch,
    ddo_stream_if.source        out_ch,
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_MULT    = 5'd1;
    localparam logic [4:0] S_HDIV    = 5'd2;
    localparam logic [4:0] S_SC      = 5'd4;
    localparam logic [4:0] S_SCW     = 5'd5;
    localparam logic [4:0] S_MX      = 5'd6;
    localparam logic [4:0] S_AX      = 5'd7;
    localparam logic [4:0] S_MY      = 5'd8;
    localparam logic [4:0] S_AY      = 5'd9;
    localparam logic [4:0] S_AT      = 5'd10;
    localparam logic [4:0] S_ATW     = 5'd11;
    localparam logic [4:0] S_HM      = 5'd12;
    localparam logic [4:0] S_HDIV2   = 5'd13;
    localparam logic [4:0] S_SDIV    = 5'd15;
    localparam logic [4:0] S_SDIVW   = 5'd16;
    localparam logic [4:0] S_OUT     = 5'd17;
    localparam logic [4:0] S_POSE    = 5'd18;
    localparam logic [4:0] S_POSE2   = 5'd19;
    localparam logic [4:0] S_MP      = 5'd20;
    localparam logic [4:0] S_MPA     = 5'd21;

    logic [4:0] state_reg;

    logic [23:0] upp_reg;
    logic [20:0] track_reg;
    logic [9:0]  period_reg;

    logic signed [31:0] pos_x_reg, pos_y_reg;
    logic [15:0]        heading_reg;
    logic signed [15:0] speed_reg;

    odo_in_t  item_reg;
    odo_out_t out_reg;
    logic     out_valid_reg;

    logic signed [41:0] dr_reg, dl_reg;
    logic signed [42:0] s2_reg;
    logic [31:0]        ang_reg;
    logic               flip_reg;
    logic signed [CW-1:0] cos_reg, sin_reg;
    logic signed [32:0] zh_reg;
    logic signed [79:0] prod_reg;
    logic signed [81:0] hsum_reg;

    // Shared 34x34 signed multiplier, reused across the sequence.
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    assign mul_p = mul_a * mul_b;

    cordic_cmd_t cmd;
    cordic_rsp_t rsp;

    ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic
    (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd),
        .rsp  (rsp)
    );

    logic        div_start;
    logic [47:0] div_num, div_den, div_q, div_r;
    logic        div_done;

    ddo_divider #(.NW(48), .DW(48)) u_div
    (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (div_den),
        .done (div_done),
        .quot (div_q),
        .rem  (div_r)
    );

    logic signed [42:0] a_adv;
    logic [42:0]        s2_mag;
    logic signed [31:0] za;
    logic signed [CW-1:0] dd;
    logic [20:0]        track_eff;
    logic [9:0]         per_eff;
    logic signed [CW-1:0] trig_sel;
    logic signed [31:0] pos_sel;
    logic signed [42:0] prod_trunc;
    logic               prod_frac;
    logic signed [43:0] newpos_raw;
    logic signed [43:0] newpos;
    logic [81:0]        hmod;
    logic [58:0]        hprod;
    logic [31:0]        hang;

    assign s2_mag    = s2_reg[42] ? 43'(-s2_reg) : s2_reg;
    // Truncating divide by 512 of a signed value.
    assign a_adv     = s2_reg[42] ? -43'(s2_mag >> 9) : 43'(s2_mag >> 9);
    assign track_eff = (track_reg == '0) ? 21'd1 : track_reg;
    assign per_eff   = (period_reg == '0) ? 10'd1 : period_reg;
    assign dd        = CW'(dl_reg) - CW'(dr_reg);

    // Heading to binary angle by a constant reciprocal multiply.
    assign hprod = 59'(heading_reg) * 59'(HEAD_RECIP);
    assign hang  = hprod[57:26];

    assign trig_sel = (state_reg == S_MX || state_reg == S_AX) ? sin_reg : cos_reg;
    assign pos_sel  = (state_reg == S_MX || state_reg == S_AX) ? pos_x_reg : pos_y_reg;
    // Product shifted down by 2^38, truncated toward zero.
    assign prod_trunc = prod_reg[79] ? -43'((-prod_reg) >>> 38) : 43'(prod_reg >>> 38);
    assign prod_frac  = |prod_reg[37:0];
    assign newpos_raw = 44'(pos_sel) + 44'(prod_trunc);
    // The dropped fraction moves the sum one step toward zero when its sign
    // differs from the sign of the sum.
    assign newpos = (newpos_raw > 0 && prod_reg[79] && prod_frac) ? newpos_raw - 44'sd1
                  : (newpos_raw < 0 && !prod_reg[79] && prod_frac) ? newpos_raw + 44'sd1
                  : newpos_raw;
    assign hmod = hsum_reg[81] ? 82'(hsum_reg + 82'(TURN_TWO32))
                : (hsum_reg >= $signed(82'(TURN_TWO32))) ? 82'(hsum_reg - 82'(TURN_TWO32))
                : 82'(hsum_reg);

    function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
        if (v > 44'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -44'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MULT:
            begin
                mul_a = 34'({1'b0, item_reg.pulses_right});
                mul_b = 34'({1'b0, upp_reg});
            end
            S_MP:
            begin
                mul_a = 34'({1'b0, item_reg.pulses_left});
                mul_b = 34'({1'b0, upp_reg});
            end
            S_MX, S_MY:
            begin
                mul_a = 34'(a_adv);
                mul_b = 34'(trig_sel);
            end
            S_POSE:
            begin
                mul_a = 34'(item_reg.set_x_mm);
                mul_b = 34'sd1000;
            end
            S_POSE2:
            begin
                mul_a = 34'(item_reg.set_y_mm);
                mul_b = 34'sd1000;
            end
            S_HM:
            begin
                mul_a = 34'(za);
                mul_b = 34'sd36000;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign za = zh_reg[31:0];

    always_comb
    begin
        cmd = '0;
        if (state_reg == S_SC)
        begin
            cmd.start     = 1'b1;
            cmd.vectoring = 1'b0;
            cmd.x0        = GAIN_Q30;
            cmd.y0        = '0;
            cmd.z0        = 33'(signed'(ang_reg));
        end
        else if (state_reg == S_AT)
        begin
            cmd.start     = 1'b1;
            cmd.vectoring = 1'b1;
            cmd.x0        = CW'({track_eff, 16'd0});
            cmd.y0        = dd;
            cmd.z0        = '0;
        end
    end

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            S_SDIV:
            begin
                div_start = 1'b1;
                div_num   = 48'(s2_mag);
                div_den   = 48'({per_eff, 17'd0});
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign in_ch.ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    logic signed [47:0] sq;
    assign sq = mul_p[47:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            upp_reg       <= 24'd1146880;
            track_reg     <= 21'd300000;
            period_reg    <= 10'd10;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            heading_reg   <= '0;
            speed_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_UM_PER_PULSE: upp_reg    <= cfg_data;
                    REG_TRACK_WIDTH:  track_reg  <= cfg_data[20:0];
                    REG_STEP_PERIOD:  period_reg <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                    if (in_ch.valid && in_ch.ready)
                        state_reg <= in_ch.data.kind ? S_POSE : S_MULT;
                S_MULT:   state_reg <= S_MP;
                S_MP:     state_reg <= S_MPA;
                S_MPA:    state_reg <= S_HDIV;
                S_HDIV:   state_reg <= S_SC;
                S_SC:     state_reg <= S_SCW;
                S_SCW:    if (rsp.done) state_reg <= S_MX;
                S_MX:     state_reg <= S_AX;
                S_AX:
                begin
                    pos_x_reg <= sat32(newpos);
                    state_reg <= S_MY;
                end
                S_MY:     state_reg <= S_AY;
                S_AY:
                begin
                    pos_y_reg <= sat32(newpos);
                    state_reg <= S_AT;
                end
                S_AT:     state_reg <= S_ATW;
                S_ATW:    if (rsp.done) state_reg <= S_HM;
                S_HM:     state_reg <= S_HDIV2;
                S_HDIV2:
                begin
                    heading_reg <= hmod[47:32];
                    state_reg   <= S_SDIV;
                end
                S_SDIV:   state_reg <= S_SDIVW;
                S_SDIVW:
                    if (div_done)
                    begin
                        if (div_q > 48'd32767)
                            speed_reg <= s2_reg[42] ? -16'sd32768 : 16'sd32767;
                        else
                            speed_reg <= s2_reg[42] ? -16'(div_q[15:0]) : 16'(div_q[15:0]);
                        state_reg <= S_OUT;
                    end
                S_POSE:
                begin
                    pos_x_reg <= mul_p[31:0];
                    state_reg <= S_POSE2;
                end
                S_POSE2:
                begin
                    pos_y_reg <= mul_p[31:0];
                    // Degrees mod 360 by a single conditional subtract.
                    if (item_reg.set_heading_deg >= 9'd360)
                        heading_reg <= 16'(item_reg.set_heading_deg - 9'd360) * 16'd100;
                    else
                        heading_reg <= 16'(item_reg.set_heading_deg) * 16'd100;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers; no reset needed.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_ch.valid && in_ch.ready)
            item_reg <= in_ch.data;
        if (state_reg == S_MULT)
            dr_reg <= item_reg.reverse_right ? -42'(mul_p[39:0]) : 42'(mul_p[39:0]);
        if (state_reg == S_MP)
            dl_reg <= item_reg.reverse_left ? -42'(mul_p[39:0]) : 42'(mul_p[39:0]);
        if (state_reg == S_MPA)
            s2_reg <= 43'(dr_reg) + 43'(dl_reg);
        if (state_reg == S_HDIV)
        begin
            // Fold second and third quadrants by a half turn.
            ang_reg  <= hang;
            flip_reg <= (hang[31:30] == 2'b01) || (hang[31:30] == 2'b10);
            if ((hang[31:30] == 2'b01) || (hang[31:30] == 2'b10))
                ang_reg <= hang - 32'h80000000;
        end
        if (state_reg == S_SCW && rsp.done)
        begin
            cos_reg <= flip_reg ? -rsp.x : rsp.x;
            sin_reg <= flip_reg ? -rsp.y : rsp.y;
        end
        if (state_reg == S_MX || state_reg == S_MY)
            prod_reg <= 80'(mul_p);
        if (state_reg == S_ATW && rsp.done)
            zh_reg <= rsp.z;
        if (state_reg == S_HM)
            hsum_reg <= 82'({heading_reg, 32'd0}) + 82'(sq);
        if (state_reg == S_OUT)
        begin
            out_reg.x_um             <= pos_x_reg;
            out_reg.y_um             <= pos_y_reg;
            out_reg.heading_centideg <= heading_reg;
            out_reg.speed_mm_s       <= speed_reg;
        end
    end

    // A new word is never taken while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !in_ch.ready)
        else $error("input accepted while result pending");

    // The heading stays inside one turn.
    assert property (@(posedge clk) disable iff (!rst_n)
        heading_reg < 16'd36000)
        else $error("heading out of range");

    // A result appears only right after the sequence ends.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result without finished sequence");

endmodule
